>>> hw/rtl/cci_pkg.sv
// Shared constants, types and helpers for the centroid image centering block.
package cci_pkg;

    // Field and size widths fixed by the register and pixel formats
    localparam int SIZE_W     = 6;
    localparam int SIZE_LIMIT = (1 << SIZE_W) - 1;
    localparam int TOTAL_W    = 2 * SIZE_W;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 4 * CHAN_W;
    // Wrapped coordinate numerator: coord + offset + 64 * size stays below 2**13
    localparam int WRAP_W     = 2 * SIZE_W + 1;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;

    localparam logic [SIZE_W-1:0] RST_FRAME_SIZE = 6'd28;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_PIXEL  = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_DIV,
        ST_LD_ACC,
        ST_LD_END,
        ST_CX_DIV,
        ST_CY_DIV,
        ST_RD_DIVP,
        ST_RD_WRAPX,
        ST_RD_WRAPY,
        ST_RD_ADDR,
        ST_RD_MEM
    } cci_state_t;

    // Clamp a size register: zero acts as one, above the limit acts as the limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/centroid_center_image_unit.sv
// Centroid image centering: frame store, centroid sums, shared divider and sequencer.
//
// Usage: the pixel channel (pix_valid / pix_stall) carries one item per transfer.
// operation = load stores the pixel in raster order and adds chan0 into the
// intensity and the column- and row-weighted sums. The load that completes the
// frame (width * height pixels) yields one report result: the rounded centroid
// minus half the frame size per axis, and blank_frame when all intensity was
// zero (offsets then zero). operation = read yields the next pixel of the frame,
// circularly shifted by the offsets; frame_last marks the final one. Reads with
// no completed frame give no result. The config channel (cfg_valid / cfg_ready)
// writes frame_width and frame_height; write it only while the block is idle.
// Timing: one restoring divider, one quotient bit per cycle, does all division.
// A load splits its position into row and column on the divider, then adds to
// the sums; the completing load adds the two centroid divisions. A read splits
// its position, wraps the column and then the row on the divider, forms the
// address and reads the store. pix_stall is high while an item is in work.
// Results sit in an output register; a stalled result holds and the sequencer
// waits for it before loading the next one. Reset clears sums, counters and
// offsets, sets both sizes to 28; the frame store is not cleared and must be
// loaded before it is read.
module centroid_center_image_unit #(
    parameter int MAX_WIDTH  = cci_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cci_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [cci_pkg::SIZE_W-1:0]        cfg_data,

    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  logic                              operation,
    input  logic [cci_pkg::CHAN_W-1:0]        chan0,
    input  logic [cci_pkg::CHAN_W-1:0]        chan1,
    input  logic [cci_pkg::CHAN_W-1:0]        chan2,
    input  logic [cci_pkg::CHAN_W-1:0]        chan3,

    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              result_kind,
    output logic signed [cci_pkg::SIZE_W-1:0] shift_x,
    output logic signed [cci_pkg::SIZE_W-1:0] shift_y,
    output logic                              blank_frame,
    output logic [cci_pkg::CHAN_W-1:0]        out0,
    output logic [cci_pkg::CHAN_W-1:0]        out1,
    output logic [cci_pkg::CHAN_W-1:0]        out2,
    output logic [cci_pkg::CHAN_W-1:0]        out3,
    output logic                              frame_last
);

    localparam int SW      = cci_pkg::SIZE_W;
    localparam int TW      = cci_pkg::TOTAL_W;
    localparam int CHW     = cci_pkg::CHAN_W;
    localparam int PW      = cci_pkg::PIX_W;
    localparam int RW      = cci_pkg::WRAP_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW      = $clog2(DEPTH);
    localparam int CMPW    = (CW + 1 > TW) ? CW + 1 : TW;
    localparam int IW      = CHW + CW;
    localparam int WSW     = CHW + 2 * CW;
    localparam int NW      = WSW + 2;
    localparam int DW      = IW + 1;
    localparam int SHORT_W = (CW > RW) ? CW : RW;
    localparam int LW      = $clog2(NW + 1);
    localparam int PXW     = SW + CHW;
    localparam int PYW     = CW + CHW;
    localparam int WLIM    = (MAX_WIDTH > cci_pkg::SIZE_LIMIT) ? cci_pkg::SIZE_LIMIT : MAX_WIDTH;
    localparam int HLIM    = (MAX_HEIGHT > cci_pkg::SIZE_LIMIT) ? cci_pkg::SIZE_LIMIT : MAX_HEIGHT;
    localparam logic [SW-1:0] WMAX = SW'(WLIM);
    localparam logic [SW-1:0] HMAX = SW'(HLIM);

    // Configuration registers
    logic [SW-1:0] frame_width_reg;
    logic [SW-1:0] frame_height_reg;

    // Control state
    cci_pkg::cci_state_t state_reg, state_next;
    logic [CW-1:0]  load_count_reg, load_count_next;
    logic [CW-1:0]  emit_count_reg, emit_count_next;
    logic           frame_ready_reg, frame_ready_next;
    logic [SW-1:0]  offset_col_reg, offset_col_next;
    logic [SW-1:0]  offset_row_reg, offset_row_next;
    logic [WSW-1:0] wx_sum_reg, wx_sum_next;
    logic [WSW-1:0] wy_sum_reg, wy_sum_next;
    logic [IW-1:0]  int_sum_reg, int_sum_next;
    logic           res_valid_reg, res_valid_next;

    // Working payload
    logic [CHW-1:0] c0_reg, c0_next;
    logic [WSW-1:0] prodx_reg, prodx_next;
    logic [WSW-1:0] prody_reg, prody_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           last_reg, last_next;
    logic [SW-1:0]  ycoord_reg, ycoord_next;
    logic [SW-1:0]  sx_reg, sx_next;
    logic [CW-1:0]  addr_reg, addr_next;
    logic [PW-1:0]  rd_data_reg;

    // Shared divider
    logic [NW-1:0]  div_num_reg;
    logic [DW-1:0]  div_rem_reg;
    logic [DW-1:0]  div_den_reg;
    logic [LW-1:0]  div_cnt_reg;
    logic           div_load;
    logic [NW-1:0]  div_num_in;
    logic [DW-1:0]  div_den_in;
    logic [LW-1:0]  div_len_in;
    logic [DW:0]    div_trial;
    logic           div_fits;
    logic [DW:0]    div_diff;
    logic           div_done;

    // Result register
    logic           res_load;
    logic           res_kind_in;
    logic [SW-1:0]  res_sx_in;
    logic [SW-1:0]  res_sy_in;
    logic           res_blank_in;
    logic [PW-1:0]  res_pix_in;
    logic           res_last_in;
    logic           res_kind_reg;
    logic [SW-1:0]  res_sx_reg;
    logic [SW-1:0]  res_sy_reg;
    logic           res_blank_reg;
    logic [PW-1:0]  res_pix_reg;
    logic           res_last_reg;

    // Derived values
    logic [SW-1:0]   eff_w;
    logic [SW-1:0]   eff_h;
    logic [TW-1:0]   total;
    logic [TW-1:0]   total_m1;
    logic            pix_accept;
    logic            cfg_accept;
    logic            res_free;
    logic            store_wr;
    logic [PW-1:0]   pix_in;
    logic [CMPW-1:0] count_inc;
    logic            load_done;
    logic [CW-1:0]   pos_sel;
    logic            last_sel;
    logic [RW-1:0]   wrapx_val;
    logic [RW-1:0]   wrapy_val;
    logic [NW-1:0]   cx_num;
    logic [NW-1:0]   cy_num;
    logic [DW-1:0]   c_den;
    logic [PXW-1:0]  mul_x;
    logic [PYW-1:0]  mul_y;
    logic [TW-1:0]   addr_val;

    (* nomem_dummy_never_used = 0 *) logic [PW-1:0] frame_store [DEPTH];

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign pix_stall  = (state_reg != cci_pkg::ST_IDLE);
    assign pix_accept = pix_valid && !pix_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign store_wr   = pix_accept && (operation == cci_pkg::OP_LOAD);
    assign pix_in     = {chan3, chan2, chan1, chan0};

    // Frame geometry from the live size registers
    assign eff_w    = cci_pkg::eff_size(frame_width_reg, WMAX);
    assign eff_h    = cci_pkg::eff_size(frame_height_reg, HMAX);
    assign total    = TW'(eff_w) * TW'(eff_h);
    assign total_m1 = total - TW'(1);

    assign count_inc = CMPW'(load_count_reg) + CMPW'(1);
    assign load_done = (count_inc >= CMPW'(total));
    assign pos_sel   = (CMPW'(emit_count_reg) >= CMPW'(total)) ? CW'(total_m1) : emit_count_reg;
    assign last_sel  = (CMPW'(pos_sel) == CMPW'(total_m1));

    // Divider operands: shifted coordinates and rounded centroid fractions
    assign wrapx_val = RW'(div_rem_reg[SW-1:0])
                     + {{(RW-SW){offset_col_reg[SW-1]}}, offset_col_reg}
                     + {1'b0, eff_w, {SW{1'b0}}};
    assign wrapy_val = RW'(ycoord_reg)
                     + {{(RW-SW){offset_row_reg[SW-1]}}, offset_row_reg}
                     + {1'b0, eff_h, {SW{1'b0}}};
    assign cx_num    = NW'({wx_sum_reg, 1'b0}) + NW'(int_sum_reg);
    assign cy_num    = NW'({wy_sum_reg, 1'b0}) + NW'(int_sum_reg);
    assign c_den     = {int_sum_reg, 1'b0};

    assign mul_x    = PXW'(div_rem_reg[SW-1:0]) * PXW'(c0_reg);
    assign mul_y    = PYW'(div_num_reg[CW-1:0]) * PYW'(c0_reg);
    assign addr_val = TW'(div_rem_reg[SW-1:0]) * TW'(eff_w) + TW'(sx_reg);

    // Restoring divider step: one quotient bit per cycle
    assign div_trial = {div_rem_reg, div_num_reg[NW-1]};
    assign div_fits  = (div_trial >= {1'b0, div_den_reg});
    assign div_diff  = div_trial - {1'b0, div_den_reg};
    assign div_done  = (div_cnt_reg == '0);

    // Sequencer: next state, divider starts, result loads
    always_comb
    begin
        state_next       = state_reg;
        load_count_next  = load_count_reg;
        emit_count_next  = emit_count_reg;
        frame_ready_next = frame_ready_reg;
        offset_col_next  = offset_col_reg;
        offset_row_next  = offset_row_reg;
        wx_sum_next      = wx_sum_reg;
        wy_sum_next      = wy_sum_reg;
        int_sum_next     = int_sum_reg;
        c0_next          = c0_reg;
        prodx_next       = prodx_reg;
        prody_next       = prody_reg;
        pos_next         = pos_reg;
        last_next        = last_reg;
        ycoord_next      = ycoord_reg;
        sx_next          = sx_reg;
        addr_next        = addr_reg;
        div_load         = 1'b0;
        div_num_in       = '0;
        div_den_in       = '0;
        div_len_in       = '0;
        res_load         = 1'b0;
        res_kind_in      = cci_pkg::KIND_REPORT;
        res_sx_in        = '0;
        res_sy_in        = '0;
        res_blank_in     = 1'b0;
        res_pix_in       = '0;
        res_last_in      = 1'b0;

        case (state_reg)
            cci_pkg::ST_IDLE:
            begin
                if (pix_accept)
                begin
                    if (operation == cci_pkg::OP_LOAD)
                    begin
                        // Start column / row split of the load position
                        frame_ready_next = 1'b0;
                        emit_count_next  = '0;
                        c0_next          = chan0;
                        div_load         = 1'b1;
                        div_num_in       = {SHORT_W'(load_count_reg), {(NW-SHORT_W){1'b0}}};
                        div_den_in       = DW'(eff_w);
                        div_len_in       = LW'(SHORT_W);
                        state_next       = cci_pkg::ST_LD_DIV;
                    end
                    else if (frame_ready_reg)
                    begin
                        // Start column / row split of the output position
                        pos_next   = pos_sel;
                        last_next  = last_sel;
                        div_load   = 1'b1;
                        div_num_in = {SHORT_W'(pos_sel), {(NW-SHORT_W){1'b0}}};
                        div_den_in = DW'(eff_w);
                        div_len_in = LW'(SHORT_W);
                        state_next = cci_pkg::ST_RD_DIVP;
                    end
                end
            end

            cci_pkg::ST_LD_DIV:
            begin
                if (div_done)
                begin
                    prodx_next = WSW'(mul_x);
                    prody_next = WSW'(mul_y);
                    state_next = cci_pkg::ST_LD_ACC;
                end
            end

            cci_pkg::ST_LD_ACC:
            begin
                wx_sum_next  = wx_sum_reg + prodx_reg;
                wy_sum_next  = wy_sum_reg + prody_reg;
                int_sum_next = int_sum_reg + IW'(c0_reg);
                if (load_done)
                begin
                    load_count_next = '0;
                    state_next      = cci_pkg::ST_LD_END;
                end
                else
                begin
                    load_count_next = CW'(count_inc);
                    state_next      = cci_pkg::ST_IDLE;
                end
            end

            cci_pkg::ST_LD_END:
            begin
                if (int_sum_reg == '0)
                begin
                    // Blank frame: report zero offsets once the output is free
                    if (res_free)
                    begin
                        offset_col_next  = '0;
                        offset_row_next  = '0;
                        wx_sum_next      = '0;
                        wy_sum_next      = '0;
                        frame_ready_next = 1'b1;
                        res_load         = 1'b1;
                        res_blank_in     = 1'b1;
                        state_next       = cci_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    div_load   = 1'b1;
                    div_num_in = cx_num;
                    div_den_in = c_den;
                    div_len_in = LW'(NW);
                    state_next = cci_pkg::ST_CX_DIV;
                end
            end

            cci_pkg::ST_CX_DIV:
            begin
                if (div_done)
                begin
                    offset_col_next = div_num_reg[SW-1:0] - (eff_w >> 1);
                    div_load        = 1'b1;
                    div_num_in      = cy_num;
                    div_den_in      = c_den;
                    div_len_in      = LW'(NW);
                    state_next      = cci_pkg::ST_CY_DIV;
                end
            end

            cci_pkg::ST_CY_DIV:
            begin
                if (div_done && res_free)
                begin
                    offset_row_next  = div_num_reg[SW-1:0] - (eff_h >> 1);
                    wx_sum_next      = '0;
                    wy_sum_next      = '0;
                    int_sum_next     = '0;
                    frame_ready_next = 1'b1;
                    res_load         = 1'b1;
                    res_sx_in        = offset_col_reg;
                    res_sy_in        = div_num_reg[SW-1:0] - (eff_h >> 1);
                    state_next       = cci_pkg::ST_IDLE;
                end
            end

            cci_pkg::ST_RD_DIVP:
            begin
                if (div_done)
                begin
                    // Remainder is the column; wrap it by the column offset
                    ycoord_next = div_num_reg[SW-1:0];
                    div_load    = 1'b1;
                    div_num_in  = {SHORT_W'(wrapx_val), {(NW-SHORT_W){1'b0}}};
                    div_den_in  = DW'(eff_w);
                    div_len_in  = LW'(SHORT_W);
                    state_next  = cci_pkg::ST_RD_WRAPX;
                end
            end

            cci_pkg::ST_RD_WRAPX:
            begin
                if (div_done)
                begin
                    sx_next    = div_rem_reg[SW-1:0];
                    div_load   = 1'b1;
                    div_num_in = {SHORT_W'(wrapy_val), {(NW-SHORT_W){1'b0}}};
                    div_den_in = DW'(eff_h);
                    div_len_in = LW'(SHORT_W);
                    state_next = cci_pkg::ST_RD_WRAPY;
                end
            end

            cci_pkg::ST_RD_WRAPY:
            begin
                if (div_done)
                begin
                    addr_next  = CW'(addr_val);
                    state_next = cci_pkg::ST_RD_ADDR;
                end
            end

            cci_pkg::ST_RD_ADDR:
            begin
                state_next = cci_pkg::ST_RD_MEM;
            end

            cci_pkg::ST_RD_MEM:
            begin
                if (res_free)
                begin
                    res_load    = 1'b1;
                    res_kind_in = cci_pkg::KIND_PIXEL;
                    res_pix_in  = rd_data_reg;
                    res_last_in = last_reg;
                    if (last_reg)
                    begin
                        emit_count_next  = '0;
                        frame_ready_next = 1'b0;
                    end
                    else
                    begin
                        emit_count_next = pos_reg + CW'(1);
                    end
                    state_next = cci_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cci_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cci_pkg::RST_FRAME_SIZE;
            frame_height_reg <= cci_pkg::RST_FRAME_SIZE;
        end
        else if (cfg_accept)
        begin
            if (cfg_index == cci_pkg::CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            else
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cci_pkg::ST_IDLE;
            load_count_reg  <= '0;
            emit_count_reg  <= '0;
            frame_ready_reg <= 1'b0;
            offset_col_reg  <= '0;
            offset_row_reg  <= '0;
            wx_sum_reg      <= '0;
            wy_sum_reg      <= '0;
            int_sum_reg     <= '0;
            res_valid_reg   <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            emit_count_reg  <= emit_count_next;
            frame_ready_reg <= frame_ready_next;
            offset_col_reg  <= offset_col_next;
            offset_row_reg  <= offset_row_next;
            wx_sum_reg      <= wx_sum_next;
            wy_sum_reg      <= wy_sum_next;
            int_sum_reg     <= int_sum_next;
            res_valid_reg   <= res_valid_next;
            if (div_load)
            begin
                div_cnt_reg <= div_len_in;
            end
            else if (!div_done)
            begin
                div_cnt_reg <= div_cnt_reg - LW'(1);
            end
        end
    end

    // Hold the result until it transfers
    assign res_valid_next = res_load || (res_valid_reg && res_stall);

    // Working payload and divider datapath
    always_ff @(posedge clk)
    begin
        c0_reg     <= c0_next;
        prodx_reg  <= prodx_next;
        prody_reg  <= prody_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        ycoord_reg <= ycoord_next;
        sx_reg     <= sx_next;
        addr_reg   <= addr_next;
        if (div_load)
        begin
            div_num_reg <= div_num_in;
            div_rem_reg <= '0;
            div_den_reg <= div_den_in;
        end
        else if (!div_done)
        begin
            div_num_reg <= {div_num_reg[NW-2:0], div_fits};
            div_rem_reg <= div_fits ? div_diff[DW-1:0] : div_trial[DW-1:0];
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_kind_reg  <= res_kind_in;
            res_sx_reg    <= res_sx_in;
            res_sy_reg    <= res_sy_in;
            res_blank_reg <= res_blank_in;
            res_pix_reg   <= res_pix_in;
            res_last_reg  <= res_last_in;
        end
    end

    // Frame store: write on load transfer, registered read
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            frame_store[load_count_reg] <= pix_in;
        end
        rd_data_reg <= frame_store[addr_reg];
    end

    assign res_valid   = res_valid_reg;
    assign result_kind = res_kind_reg;
    assign shift_x     = $signed(res_sx_reg);
    assign shift_y     = $signed(res_sy_reg);
    assign blank_frame = res_blank_reg;
    assign out0        = res_pix_reg[CHW-1:0];
    assign out1        = res_pix_reg[2*CHW-1:CHW];
    assign out2        = res_pix_reg[3*CHW-1:2*CHW];
    assign out3        = res_pix_reg[4*CHW-1:3*CHW];
    assign frame_last  = res_last_reg;

    // Divider is never restarted mid-division
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_load |-> div_done)
        else $error("divider restarted while busy");

    // A waiting result is never overwritten
    a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || !res_stall))
        else $error("result register overwritten");

    // Input stays stalled while the divider runs
    a_stall_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        !div_done |-> pix_stall)
        else $error("input open during division");

    // Final output pixel closes the frame
    a_last_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_kind_in == cci_pkg::KIND_PIXEL && res_last_in) |=> !frame_ready_reg)
        else $error("frame still ready after last pixel");

    // Report leaves a ready frame and a fresh load count
    a_report_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_kind_in == cci_pkg::KIND_REPORT)
            |=> (frame_ready_reg && load_count_reg == '0))
        else $error("report without frame ready");

endmodule
